/* sv/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define HFF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hff assertion failed");

// next-cycle implication
`define HFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hff assertion failed");

`endif

/* sv/hff_pkg.sv */
// shared constants and character helpers for the hex field formatter
package hff_pkg;

    localparam int MAX_FIELD = 64;

    localparam int MODE_W  = 2;
    localparam int VALUE_W = 64;
    localparam int WIDTH_W = 7;
    localparam int PREC_W  = 6;
    localparam int CHAR_W  = 8;

    localparam logic [MODE_W-1:0] MODE_LOWER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPPER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PTR   = 2'd2;

    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LOW_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;

    // "(nil)"
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6e;
    localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
    localparam logic [CHAR_W-1:0] CH_L      = 8'h6c;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam int                NIL_LEN   = 5;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UP_A : CH_LOW_A;
        if (d < 4'd10)
            return CH_ZERO + CHAR_W'(d);
        else
            return base + CHAR_W'(d) - 8'd10;
    endfunction

    function automatic logic [CHAR_W-1:0] nil_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            3'd0:    c = CH_LPAREN;
            3'd1:    c = CH_N;
            3'd2:    c = CH_I;
            3'd3:    c = CH_L;
            default: c = CH_RPAREN;
        endcase
        return c;
    endfunction

endpackage

/* sv/hff_if.sv */
// valid/ready channel interfaces for the formatter request and character items
interface hff_in_if;
    import hff_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [VALUE_W-1:0]   value;
    logic [WIDTH_W-1:0]   width;
    logic                 has_precision;
    logic [PREC_W-1:0]    precision;
    logic                 precision_negative;
    logic                 left_justify;
    logic                 zero_pad;
    logic                 alt_prefix;

    modport source (
        output valid, mode, value, width, has_precision, precision,
               precision_negative, left_justify, zero_pad, alt_prefix,
        input  ready
    );

    modport sink (
        input  valid, mode, value, width, has_precision, precision,
               precision_negative, left_justify, zero_pad, alt_prefix,
        output ready
    );
endinterface

interface hff_out_if;
    import hff_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (
        output valid, out_char, last,
        input  ready
    );

    modport sink (
        input  valid, out_char, last,
        output ready
    );
endinterface

/* sv/hex_field_formatter.sv */
// printf-style hex and pointer field formatter, at most one character item per cycle
// Usage: one request item (number plus printf options) is taken while the block
// is idle; the block then sends the formatted field as a run of character items,
// the final one marked with last, and an empty field sends nothing at all. A
// request first runs through a leading-zero scan on the one nibble shifter (one
// nibble per cycle, up to 15 nibbles shifted), then the sizing states S_LEN,
// S_SIZE and S_SUM, and then the emit sequencer sends one character per cycle
// while the sink holds ready high, pausing to step over each finished or empty
// field segment. A field holds at most 64 characters. The next request is taken
// on the cycle after the last character enters the output register.
// Width saturates at 64 and precision at 62; pointer zero without precision
// gives "(nil)", and in pointer mode a zero-pad flag puts "0x" before the pad.
module hex_field_formatter (
    input logic      clk,
    input logic      rst_n,
    hff_in_if.sink   in_ch,
    hff_out_if.source out_ch
);
    import hff_pkg::*;

    localparam logic [PREC_W-1:0]  PREC_MAX  = PREC_W'(MAX_FIELD - 2);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_FIELD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LEN,
        S_SIZE,
        S_SUM,
        S_EMIT
    } state_t;

    // field segments in the order they leave the block
    typedef enum logic [2:0] {
        SEG_NIL,
        SEG_PRE_A,
        SEG_PAD,
        SEG_PRE_B,
        SEG_ZERO,
        SEG_DIG,
        SEG_TRAIL
    } seg_t;

    state_t                    state_reg, state_next;
    seg_t                      seg_reg, seg_next;

    // shared nibble shifter: leading-zero scan, then digit output
    logic [VALUE_W-1:0]        scan_reg, scan_next;
    logic [3:0]                sc_reg, sc_next;

    // latched options
    logic                      ptr_reg, ptr_next;
    logic                      upper_reg, upper_next;
    logic                      nz_reg, nz_next;
    logic                      dot_reg, dot_next;
    logic                      neg_reg, neg_next;
    logic [PREC_W-1:0]         p_reg, p_next;
    logic [WIDTH_W-1:0]        w_reg, w_next;
    logic                      minus_reg, minus_next;
    logic                      zero_reg, zero_next;
    logic                      sharp_reg, sharp_next;

    // sizing results
    logic [PREC_W-1:0]         prec_reg, prec_next;
    logic signed [7:0]         fw_reg, fw_next;
    logic [4:0]                dlen_reg, dlen_next;
    logic                      nil_reg, nil_next;
    logic [1:0]                pre_a_reg, pre_a_next;
    logic [1:0]                pre_b_reg, pre_b_next;
    logic [WIDTH_W-1:0]        pad_reg, pad_next;
    logic [WIDTH_W-1:0]        trail_reg, trail_next;
    logic [PREC_W-1:0]         zc_reg, zc_next;
    logic [CHAR_W-1:0]         padch_reg, padch_next;
    logic [WIDTH_W-1:0]        total_reg, total_next;

    // emit counters and output register
    logic [WIDTH_W-1:0]        rem_reg, rem_next;
    logic [WIDTH_W-1:0]        cnt_reg, cnt_next;
    logic                      ov_reg, ov_next;
    logic [CHAR_W-1:0]         oc_reg, oc_next;
    logic                      ol_reg, ol_next;

    // combinational helpers
    logic                      in_fire;
    logic                      out_fire;
    logic [4:0]                len_nat;
    logic [4:0]                len_c;
    logic [PREC_W-1:0]         prec_c;
    logic                      gt_c;
    logic signed [7:0]         diff_c;
    logic [7:0]                sum_c;
    seg_t                      seg_after;
    logic [WIDTH_W-1:0]        len_after;
    logic [CHAR_W-1:0]         char_c;
    logic                      last_c;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = ov_reg && out_ch.ready;

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = ov_reg;
    assign out_ch.out_char = oc_reg;
    assign out_ch.last     = ol_reg;

    // natural digit count from the leading-zero scan
    assign len_nat = 5'd16 - 5'(sc_reg);

    // width less precision, field width may have gone negative
    assign diff_c = fw_reg - $signed({2'b00, prec_reg});
    assign gt_c   = fw_reg > $signed({2'b00, prec_reg});

    assign sum_c = (nil_reg ? 8'(NIL_LEN) : 8'd0) + 8'(pre_a_reg) + 8'(pad_reg)
                 + 8'(pre_b_reg) + 8'(zc_reg) + 8'(dlen_reg) + 8'(trail_reg);

    assign last_c = (cnt_reg + 7'd1) == total_reg;

    // next segment and its length
    always_comb
    begin
        seg_after = SEG_TRAIL;
        len_after = '0;
        unique case (seg_reg)
            SEG_NIL:
            begin
                seg_after = SEG_PRE_A;
                len_after = WIDTH_W'(pre_a_reg);
            end
            SEG_PRE_A:
            begin
                seg_after = SEG_PAD;
                len_after = pad_reg;
            end
            SEG_PAD:
            begin
                seg_after = SEG_PRE_B;
                len_after = WIDTH_W'(pre_b_reg);
            end
            SEG_PRE_B:
            begin
                seg_after = SEG_ZERO;
                len_after = WIDTH_W'(zc_reg);
            end
            SEG_ZERO:
            begin
                seg_after = SEG_DIG;
                len_after = WIDTH_W'(dlen_reg);
            end
            SEG_DIG:
            begin
                seg_after = SEG_TRAIL;
                len_after = trail_reg;
            end
            SEG_TRAIL:
            begin
                seg_after = SEG_TRAIL;
                len_after = '0;
            end
            default:
            begin
                seg_after = SEG_TRAIL;
                len_after = '0;
            end
        endcase
    end

    // character for the current segment position
    always_comb
    begin
        case (seg_reg) inside
            SEG_NIL:               char_c = nil_char(3'(7'(NIL_LEN) - rem_reg));
            SEG_PRE_A, SEG_PRE_B:  char_c = (rem_reg == 7'd2) ? CH_ZERO
                                          : (upper_reg ? CH_UP_X : CH_LOW_X);
            SEG_PAD:               char_c = padch_reg;
            SEG_ZERO:              char_c = CH_ZERO;
            SEG_DIG:               char_c = hex_char(scan_reg[VALUE_W-1 -: 4], upper_reg);
            default:               char_c = CH_SPACE;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        scan_next  = scan_reg;
        sc_next    = sc_reg;
        ptr_next   = ptr_reg;
        upper_next = upper_reg;
        nz_next    = nz_reg;
        dot_next   = dot_reg;
        neg_next   = neg_reg;
        p_next     = p_reg;
        w_next     = w_reg;
        minus_next = minus_reg;
        zero_next  = zero_reg;
        sharp_next = sharp_reg;
        prec_next  = prec_reg;
        fw_next    = fw_reg;
        dlen_next  = dlen_reg;
        nil_next   = nil_reg;
        pre_a_next = pre_a_reg;
        pre_b_next = pre_b_reg;
        pad_next   = pad_reg;
        trail_next = trail_reg;
        zc_next    = zc_reg;
        padch_next = padch_reg;
        total_next = total_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ch.ready;
        oc_next    = oc_reg;
        ol_next    = ol_reg;
        len_c      = '0;
        prec_c     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ptr_next   = (in_ch.mode == MODE_PTR);
                    upper_next = (in_ch.mode == MODE_UPPER);
                    scan_next  = (in_ch.mode == MODE_PTR) ? in_ch.value
                               : {32'd0, in_ch.value[31:0]};
                    nz_next    = (in_ch.mode == MODE_PTR) ? (in_ch.value != '0)
                               : (in_ch.value[31:0] != 32'd0);
                    dot_next   = in_ch.has_precision || in_ch.precision_negative;
                    neg_next   = in_ch.precision_negative;
                    p_next     = (in_ch.precision > PREC_MAX) ? PREC_MAX : in_ch.precision;
                    w_next     = (in_ch.width > WIDTH_MAX) ? WIDTH_MAX : in_ch.width;
                    minus_next = in_ch.left_justify;
                    zero_next  = in_ch.zero_pad;
                    sharp_next = in_ch.alt_prefix;
                    sc_next    = '0;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one nibble per cycle until the top nibble is nonzero or fifteen nibbles have shifted
                if (scan_reg[VALUE_W-1 -: 4] == 4'd0 && sc_reg != 4'd15)
                begin
                    scan_next = scan_reg << 4;
                    sc_next   = sc_reg + 4'd1;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                // zero with an explicit precision of 0 has no digits
                len_c = (!nz_reg && dot_reg && !neg_reg && p_reg == '0) ? 5'd0 : len_nat;
                prec_c = neg_reg ? PREC_W'(len_c) : p_reg;
                if (prec_c < PREC_W'(len_c) || !dot_reg)
                    prec_c = PREC_W'(len_c);
                prec_next = prec_c;
                dlen_next = nz_reg ? len_c : 5'd0;
                nil_next  = ptr_reg && !nz_reg && !dot_reg;
                fw_next   = $signed({1'b0, w_reg})
                          - ((ptr_reg || (sharp_reg && nz_reg)) ? 8'sd2 : 8'sd0);
                state_next = S_SIZE;
            end
            S_SIZE:
            begin
                pad_next   = (!nil_reg && !minus_reg && gt_c) ? diff_c[WIDTH_W-1:0] : '0;
                trail_next = (!nil_reg && minus_reg && gt_c) ? diff_c[WIDTH_W-1:0] : '0;
                zc_next    = nil_reg ? '0 : prec_reg - PREC_W'(dlen_reg);
                if (nil_reg)
                begin
                    pre_a_next = 2'd0;
                    pre_b_next = 2'd0;
                end
                else if (ptr_reg)
                begin
                    // pointer prefix goes before the pad when zero padding
                    pre_a_next = zero_reg ? 2'd2 : 2'd0;
                    pre_b_next = zero_reg ? 2'd0 : 2'd2;
                end
                else
                begin
                    pre_a_next = (sharp_reg && zero_reg && nz_reg) ? 2'd2 : 2'd0;
                    pre_b_next = (sharp_reg && !zero_reg && nz_reg) ? 2'd2 : 2'd0;
                end
                if (ptr_reg)
                    padch_next = (!dot_reg && zero_reg) ? CH_ZERO : CH_SPACE;
                else
                    padch_next = ((!dot_reg || neg_reg) && zero_reg) ? CH_ZERO : CH_SPACE;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                total_next = (sum_c > 8'(MAX_FIELD)) ? WIDTH_MAX : sum_c[WIDTH_W-1:0];
                seg_next   = SEG_NIL;
                rem_next   = nil_reg ? WIDTH_W'(NIL_LEN) : '0;
                if (sum_c == 8'd0)
                    state_next = S_IDLE;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (rem_reg == '0)
                begin
                    // step over a finished or empty segment
                    if (seg_reg == SEG_TRAIL)
                        state_next = S_IDLE;
                    seg_next = seg_after;
                    rem_next = len_after;
                end
                else if (!ov_reg || out_ch.ready)
                begin
                    ov_next  = 1'b1;
                    oc_next  = char_c;
                    ol_next  = last_c;
                    rem_next = rem_reg - 7'd1;
                    cnt_next = cnt_reg + 7'd1;
                    if (seg_reg == SEG_DIG)
                        scan_next = scan_reg << 4;
                    if (last_c)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seg_reg   <= SEG_NIL;
            scan_reg  <= '0;
            sc_reg    <= '0;
            ptr_reg   <= 1'b0;
            upper_reg <= 1'b0;
            nz_reg    <= 1'b0;
            dot_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            p_reg     <= '0;
            w_reg     <= '0;
            minus_reg <= 1'b0;
            zero_reg  <= 1'b0;
            sharp_reg <= 1'b0;
            prec_reg  <= '0;
            fw_reg    <= '0;
            dlen_reg  <= '0;
            nil_reg   <= 1'b0;
            pre_a_reg <= '0;
            pre_b_reg <= '0;
            pad_reg   <= '0;
            trail_reg <= '0;
            zc_reg    <= '0;
            padch_reg <= CH_SPACE;
            total_reg <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            oc_reg    <= '0;
            ol_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            scan_reg  <= scan_next;
            sc_reg    <= sc_next;
            ptr_reg   <= ptr_next;
            upper_reg <= upper_next;
            nz_reg    <= nz_next;
            dot_reg   <= dot_next;
            neg_reg   <= neg_next;
            p_reg     <= p_next;
            w_reg     <= w_next;
            minus_reg <= minus_next;
            zero_reg  <= zero_next;
            sharp_reg <= sharp_next;
            prec_reg  <= prec_next;
            fw_reg    <= fw_next;
            dlen_reg  <= dlen_next;
            nil_reg   <= nil_next;
            pre_a_reg <= pre_a_next;
            pre_b_reg <= pre_b_next;
            pad_reg   <= pad_next;
            trail_reg <= trail_next;
            zc_reg    <= zc_next;
            padch_reg <= padch_next;
            total_reg <= total_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            oc_reg    <= oc_next;
            ol_reg    <= ol_next;
        end
    end

`include "assert_macros.svh"

    // characters sent never run past the sized field
    `HFF_ASSERT_NOW(a_cnt_bound, state_reg == S_EMIT, cnt_reg < total_reg)
    // a nil field is exactly five characters
    `HFF_ASSERT_NOW(a_nil_len, state_reg == S_EMIT && nil_reg, total_reg == 7'(NIL_LEN))
    // final character taken while no new field is being sent: output register empties
    `HFF_ASSERT_NEXT(a_last_gap, out_fire && ol_reg && state_reg != S_EMIT, !ov_reg)
    // a new request always starts with the leading-zero scan
    `HFF_ASSERT_NEXT(a_accept_scan, in_fire, state_reg == S_SCAN)

endmodule
